>>> rtl/elf_reloc_word_patcher_defines.svh
// Assertion macros for the relocation word patcher.
// Each expects signal clk, and all but ERWP_ASSERT_ALWAYS also rst_n, in the scope where it is used.
`ifndef ELF_RELOC_WORD_PATCHER_DEFINES_SVH
`define ELF_RELOC_WORD_PATCHER_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ERWP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("erwp assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define ERWP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("erwp assertion failed");

// Same-cycle implication that is also checked around reset.
`define ERWP_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("erwp assertion failed");

`endif

>>> rtl/erwp_pkg.sv
`timescale 1ns / 1ps
package erwp_pkg;

  // ARM relocation types
  localparam logic [7:0] ARM_PC24    = 8'd1;
  localparam logic [7:0] ARM_ABS32   = 8'd2;
  localparam logic [7:0] ARM_CALL    = 8'd28;
  localparam logic [7:0] ARM_JUMP24  = 8'd29;
  localparam logic [7:0] ARM_PREL31  = 8'd42;
  localparam logic [7:0] ARM_MOVW_NC = 8'd43;
  localparam logic [7:0] ARM_MOVT    = 8'd44;

  // i386 relocation types
  localparam logic [7:0] I386_32   = 8'd1;
  localparam logic [7:0] I386_PC32 = 8'd2;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_UNLINK = 2'd1;
  localparam logic [1:0] ST_BAD_RELINK = 2'd2;

  // architecture select
  localparam logic ARCH_ARM  = 1'b0;
  localparam logic ARCH_I386 = 1'b1;

  // PC bias added to the place address
  localparam logic [31:0] ARM_PC_BIAS  = 32'd8;
  localparam logic [31:0] I386_PC_BIAS = 32'd4;

  // decoupling queue depth
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // operation class decided by the front end
  typedef enum logic [2:0] {
    CLS_BRANCH,
    CLS_ABS,
    CLS_MOVW,
    CLS_MOVT,
    CLS_PREL31,
    CLS_PC32,
    CLS_BAD
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic        relink;
    logic [31:0] word;
    logic [31:0] sym;
    logic [31:0] pofs;   // place address plus PC bias (plain place for PREL31)
  } item_t;

endpackage

>>> rtl/elf_reloc_word_patcher.sv
`timescale 1ns / 1ps
// ELF32 relocation word patcher for ARM and i386. Each input transfer carries
// one word from a relocation site with its site address, relocation type and
// symbol value; each produces exactly one output transfer with the patched
// word and a status (0 ok, 1 unknown type while unlinking, 2 unknown type
// while relinking; on error the word comes back unchanged). op = 0 unlinks
// (removes the symbol contribution, leaving the addend), op = 1 relinks
// (applies the symbol at the new site). cfg_data bit 0 selects the rule set:
// 0 ARM (PC24/CALL/JUMP24, ABS32, MOVW_ABS_NC, MOVT_ABS, PREL31), 1 i386
// (32, PC32). Write it only while no transfers are in flight. Throughput is
// one transfer per clock with no bubbles while out_tready stays high; the
// result passes a decode register, a two-entry queue and the output register
// that holds the 32-bit add/subtract paths. A stall on the output side backs
// up into the queue before in_tready drops.
module elf_reloc_word_patcher (
  input  logic         clk,
  input  logic         rst_n,
  // configuration
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data,     // target_arch
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,     // [31:0] word_in, [63:32] place_addr,
                                     // [95:64] symbol_value
  input  logic [15:0]  in_tuser,     // [0] op, [8:1] reloc_type, [15:9] zero
  // output stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,    // [31:0] word_out
  output logic [7:0]   out_tuser     // [1:0] status, [7:2] zero
);

  logic            arch_r, arch_nxt;
  logic            push_valid, push_ready;
  erwp_pkg::item_t push_item;
  logic            pop_valid, pop_ready;
  erwp_pkg::item_t pop_item;
  logic [1:0]      status;

  // configuration register, always ready
  assign cfg_ready = 1'b1;
  assign arch_nxt  = (cfg_valid && cfg_ready) ? cfg_data : arch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_r <= erwp_pkg::ARCH_ARM;
    end else begin
      arch_r <= arch_nxt;
    end
  end

  // front end: decode type into an operation class, precompute P + bias
  erwp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .arch         (arch_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .op           (in_tuser[0]),
    .reloc_type   (in_tuser[8:1]),
    .word_in      (in_tdata[31:0]),
    .place_addr   (in_tdata[63:32]),
    .symbol_value (in_tdata[95:64]),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  // decoupling queue
  erwp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // back end: apply the arithmetic and hold the result
  erwp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .word_out  (out_tdata),
    .status    (status)
  );

  assign out_tuser = {6'b0, status};

endmodule

>>> rtl/erwp_front.sv
`timescale 1ns / 1ps
module erwp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               arch,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [7:0]         reloc_type,
  input  logic [31:0]        word_in,
  input  logic [31:0]        place_addr,
  input  logic [31:0]        symbol_value,
  output logic               push_valid,
  input  logic               push_ready,
  output erwp_pkg::item_t    push_item
);

  logic            valid_r;
  logic            valid_nxt;
  erwp_pkg::item_t item_r;
  erwp_pkg::cls_t  cls;
  logic [31:0]     pofs;
  logic            advance;

  // type decode per architecture
  always_comb begin
    cls  = erwp_pkg::CLS_BAD;
    pofs = place_addr + erwp_pkg::ARM_PC_BIAS;
    if (arch == erwp_pkg::ARCH_I386) begin
      pofs = place_addr + erwp_pkg::I386_PC_BIAS;
      unique case (reloc_type)
        erwp_pkg::I386_32:   cls = erwp_pkg::CLS_ABS;
        erwp_pkg::I386_PC32: cls = erwp_pkg::CLS_PC32;
        default:             cls = erwp_pkg::CLS_BAD;
      endcase
    end else begin
      unique case (reloc_type) inside
        erwp_pkg::ARM_PC24, erwp_pkg::ARM_CALL, erwp_pkg::ARM_JUMP24:
          cls = erwp_pkg::CLS_BRANCH;
        erwp_pkg::ARM_ABS32:   cls = erwp_pkg::CLS_ABS;
        erwp_pkg::ARM_MOVW_NC: cls = erwp_pkg::CLS_MOVW;
        erwp_pkg::ARM_MOVT:    cls = erwp_pkg::CLS_MOVT;
        erwp_pkg::ARM_PREL31: begin
          cls  = erwp_pkg::CLS_PREL31;
          pofs = place_addr;
        end
        default:               cls = erwp_pkg::CLS_BAD;
      endcase
    end
  end

  assign advance   = !valid_r || push_ready;
  assign in_ready  = advance;
  assign valid_nxt = advance ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      item_r.cls    <= cls;
      item_r.relink <= op;
      item_r.word   <= word_in;
      item_r.sym    <= symbol_value;
      item_r.pofs   <= pofs;
    end
  end

  assign push_valid = valid_r;
  assign push_item  = item_r;

endmodule

>>> rtl/erwp_fifo.sv
`timescale 1ns / 1ps
module erwp_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  erwp_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output erwp_pkg::item_t pop_item
);

  localparam int D = erwp_pkg::FIFO_DEPTH;

  erwp_pkg::item_t                 mem [D];
  logic [erwp_pkg::PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [erwp_pkg::PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [erwp_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic                            do_push, do_pop;

  assign push_ready = (count_r < erwp_pkg::CNT_W'(D));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == erwp_pkg::PTR_W'(D - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == erwp_pkg::PTR_W'(D - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/erwp_back.sv
`timescale 1ns / 1ps
module erwp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  erwp_pkg::item_t pop_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     word_out,
  output logic [1:0]      status
);

  logic        valid_r, valid_nxt;
  logic [31:0] word_r, word_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        take;

  assign pop_ready = !valid_r || out_ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    logic [31:0] w, s, p, a, v;
    logic [15:0] imm16, s16, v16;
    w          = pop_item.word;
    s          = pop_item.sym;
    p          = pop_item.pofs;
    a          = {{6{w[23]}}, w[23:0], 2'b00};
    imm16      = {w[19:16], w[11:0]};
    s16        = (pop_item.cls == erwp_pkg::CLS_MOVT) ? s[31:16] : s[15:0];
    v16        = pop_item.relink ? imm16 + s16 : imm16 - s16;
    v          = '0;
    word_nxt   = w;
    status_nxt = erwp_pkg::ST_OK;
    unique case (pop_item.cls)
      erwp_pkg::CLS_BRANCH: begin
        v        = pop_item.relink ? (s + a) - p : (a - s) + p;
        word_nxt = {w[31:24], v[25:2]};
      end
      erwp_pkg::CLS_ABS: word_nxt = pop_item.relink ? w + s : w - s;
      erwp_pkg::CLS_MOVW, erwp_pkg::CLS_MOVT:
        word_nxt = {w[31:20], v16[15:12], w[15:12], v16[11:0]};
      erwp_pkg::CLS_PREL31: begin
        v = (w + s) - p;
        if (pop_item.relink) begin
          word_nxt = {1'b0, v[30:0]};
        end
      end
      erwp_pkg::CLS_PC32: word_nxt = pop_item.relink ? (s + w) - p : (w - s) + p;
      default: begin
        status_nxt = pop_item.relink ? erwp_pkg::ST_BAD_RELINK : erwp_pkg::ST_BAD_UNLINK;
      end
    endcase
  end

  assign valid_nxt = pop_ready ? pop_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r   <= word_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid = valid_r;
  assign word_out  = word_r;
  assign status    = status_r;

endmodule

>>> rtl/erwp_checker.sv
`timescale 1ns / 1ps
`include "elf_reloc_word_patcher_defines.svh"
module erwp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [7:0]  out_tuser
);

  // held output stays put
  `ERWP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable({out_tdata, out_tuser}))

  // status is one of the three legal codes, padding stays zero
  `ERWP_ASSERT_NOW(a_status_legal, out_tvalid, (out_tuser[1:0] <= erwp_pkg::ST_BAD_RELINK) && (out_tuser[7:2] == 6'd0))

  // input only closes while a result is waiting on the output
  `ERWP_ASSERT_NOW(a_stall_source, !in_tready, out_tvalid)

  // first cycle out of reset: nothing pending and the input open
  `ERWP_ASSERT_ALWAYS(a_reset_clear, rst_n && $past(!rst_n), !out_tvalid && in_tready)

endmodule

bind elf_reloc_word_patcher erwp_checker u_erwp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Relocation word patcher: directed and random transfers, checked in order
// against a predictor of the ARM and i386 patch rules.
module testbench;

  // Slowest correct run stays well below this: ~1700 transfers, random idle
  // gaps, 57% receiver stall and one long hold-off.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Pause after draining: decode reg + two-entry queue + output reg, with slack.
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  status;
  } patch_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;   // [31:0] word_in, [63:32] place_addr, [95:64] symbol_value
  logic [15:0] in_tuser = '0;   // [0] op, [8:1] reloc_type, [15:9] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] word_out
  logic [7:0]  out_tuser;       // [1:0] status, [7:2] zero

  // Predictor copy of the architecture register.
  logic        arch_sel = erwp_pkg::ARCH_ARM;
  // Patched words still owed by the block, oldest first.
  patch_t      pending_patches[$];
  int unsigned bad_count = 0;
  int unsigned cycle_count = 0;
  // Idle/stall odds in percent, changed per test.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  // Long receiver hold-off, counted down by the tready process.
  int unsigned tready_hold = 0;

  elf_reloc_word_patcher uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run-length watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or a forced hold-off while tready_hold runs down.
  always @(posedge clk) begin
    if (tready_hold > 0) begin
      out_tready <= 1'b0;
      tready_hold <= tready_hold - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Expected patch for one item. Arithmetic wraps at its width (32 bits, 16 for imm16).
  function automatic patch_t patch_word(logic arch, logic relink, logic [7:0] rtype,
                                        logic [31:0] w, logic [31:0] p, logic [31:0] s);
    patch_t      r;
    logic [31:0] addend;
    logic [31:0] v;
    logic [15:0] imm;
    logic [15:0] half;
    logic        known;
    r.word = w;
    r.status = erwp_pkg::ST_OK;
    known = 1'b1;
    if (arch == erwp_pkg::ARCH_ARM) begin
      case (rtype)
        erwp_pkg::ARM_PC24, erwp_pkg::ARM_CALL, erwp_pkg::ARM_JUMP24: begin
          // imm24 << 2, sign-extended from bit 25
          addend = {{6{w[23]}}, w[23:0], 2'b00};
          v = relink ? (s + addend) - (p + erwp_pkg::ARM_PC_BIAS)
                     : addend - (s - (p + erwp_pkg::ARM_PC_BIAS));
          r.word = {w[31:24], v[25:2]};
        end
        erwp_pkg::ARM_ABS32: r.word = relink ? w + s : w - s;
        erwp_pkg::ARM_MOVW_NC, erwp_pkg::ARM_MOVT: begin
          // imm16 is split: word[19:16] high nibble, word[11:0] low bits
          imm = {w[19:16], w[11:0]};
          half = (rtype == erwp_pkg::ARM_MOVT) ? s[31:16] : s[15:0];
          imm = relink ? imm + half : imm - half;
          r.word = {w[31:20], imm[15:12], w[15:12], imm[11:0]};
        end
        erwp_pkg::ARM_PREL31: begin
          // unlink: word already holds the addend
          v = w + s - p;
          r.word = relink ? {1'b0, v[30:0]} : w;
        end
        default: known = 1'b0;
      endcase
    end else begin
      case (rtype)
        erwp_pkg::I386_32:   r.word = relink ? w + s : w - s;
        erwp_pkg::I386_PC32: r.word = relink ? (s + w) - (p + erwp_pkg::I386_PC_BIAS)
                                             : w - (s - (p + erwp_pkg::I386_PC_BIAS));
        default:             known = 1'b0;
      endcase
    end
    if (!known) begin
      r.word = w;
      r.status = relink ? erwp_pkg::ST_BAD_RELINK : erwp_pkg::ST_BAD_UNLINK;
    end
    return r;
  endfunction

  // Output checker: every result transfer against the oldest pending patch.
  always @(posedge clk) begin
    patch_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_patches.size() == 0) begin
        $display("%0t: unexpected result, word %h status %0d", $time, out_tdata,
                 out_tuser[1:0]);
        bad_count++;
      end else begin
        want = pending_patches.pop_front();
        if (out_tdata !== want.word) begin
          $display("%0t: word_out expected %h, got %h", $time, want.word, out_tdata);
          bad_count++;
        end
        if (out_tuser[1:0] !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_tuser[1:0]);
          bad_count++;
        end
      end
    end
  end

  // One input transfer, after a random idle gap. Valid stays high on return
  // so back-to-back items need no extra edge.
  task automatic send_item(logic op, logic [7:0] rtype, logic [31:0] w, logic [31:0] p,
                           logic [31:0] s);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {s, p, w};
    in_tuser <= {7'b0, rtype, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_patches.push_back(patch_word(arch_sel, op, rtype, w, p, s));
  endtask

  // Stop sending and let every owed result come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_patches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Architecture register write; only done with the block empty.
  task automatic set_arch(logic arch);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= arch;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    arch_sel = arch;
  endtask

  // Field values biased toward the wrap points.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly types valid for the current architecture, the rest any 8-bit value.
  function automatic logic [7:0] pick_type();
    if ($urandom_range(99) >= 85) return 8'($urandom_range(255));
    if (arch_sel == erwp_pkg::ARCH_I386) begin
      return $urandom_range(1) ? erwp_pkg::I386_PC32 : erwp_pkg::I386_32;
    end
    case ($urandom_range(6))
      0:       return erwp_pkg::ARM_PC24;
      1:       return erwp_pkg::ARM_ABS32;
      2:       return erwp_pkg::ARM_CALL;
      3:       return erwp_pkg::ARM_JUMP24;
      4:       return erwp_pkg::ARM_PREL31;
      5:       return erwp_pkg::ARM_MOVW_NC;
      default: return erwp_pkg::ARM_MOVT;
    endcase
  endfunction

  task automatic send_random();
    send_item(1'($urandom_range(1)), pick_type(), pick_word(), pick_word(), pick_word());
  endtask

  // ARM rules: every type, all but CALL and JUMP24 both ways, sign and carry edges, unknown types.
  task automatic test_directed_arm();
    set_arch(erwp_pkg::ARCH_ARM);
    send_idle_pct = 0;
    stall_pct = 0;
    send_item(1'b0, erwp_pkg::ARM_PC24,    32'hEA00_0000, 32'h0000_1000, 32'h0000_2000);
    send_item(1'b1, erwp_pkg::ARM_PC24,    32'hEBFF_FFFE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(1'b1, erwp_pkg::ARM_CALL,    32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    // addend sign bit just set
    send_item(1'b0, erwp_pkg::ARM_JUMP24,  32'h0080_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(1'b0, erwp_pkg::ARM_ABS32,   32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(1'b1, erwp_pkg::ARM_ABS32,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
    // imm16 borrow and carry across the split field
    send_item(1'b0, erwp_pkg::ARM_MOVW_NC, 32'hE300_0000, 32'h0000_0000, 32'h0000_0001);
    send_item(1'b1, erwp_pkg::ARM_MOVW_NC, 32'hE34F_0FFF, 32'h1234_5678, 32'hFFFF_0001);
    send_item(1'b0, erwp_pkg::ARM_MOVT,    32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5678);
    send_item(1'b1, erwp_pkg::ARM_MOVT,    32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // PREL31: unlink leaves the word, relink clears bit 31
    send_item(1'b0, erwp_pkg::ARM_PREL31,  32'hFFFF_FFFF, 32'h0000_0010, 32'h0000_0020);
    send_item(1'b1, erwp_pkg::ARM_PREL31,  32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001);
    send_item(1'b0, 8'd0,                  32'hDEAD_BEEF, 32'h0000_0000, 32'h0000_0000);
    send_item(1'b1, 8'd255,                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(1'b0, erwp_pkg::ARM_JUMP24 + 8'd1, 32'h1234_5678, 32'h0000_0100,
              32'h0000_0200);
  endtask

  // i386 rules, plus ARM-only type numbers that must now be rejected.
  task automatic test_directed_i386();
    set_arch(erwp_pkg::ARCH_I386);
    send_item(1'b0, erwp_pkg::I386_32,   32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    send_item(1'b1, erwp_pkg::I386_32,   32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    send_item(1'b0, erwp_pkg::I386_PC32, 32'h0000_0000, 32'hFFFF_FFFC, 32'h0000_0000);
    send_item(1'b1, erwp_pkg::I386_PC32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(1'b1, erwp_pkg::ARM_CALL,  32'h0102_0304, 32'h0000_0000, 32'h0000_0000);
    send_item(1'b0, erwp_pkg::ARM_MOVT,  32'hA5A5_A5A5, 32'h0000_0000, 32'h0000_0000);
    send_item(1'b0, 8'd0,                32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(1'b1, 8'd255,              32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
  endtask

  task automatic test_random(int unsigned count, logic arch, int unsigned idle,
                             int unsigned stall);
    set_arch(arch);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_random();
  endtask

  // Receiver holds off long enough for the pipeline to fill and drop in_tready.
  task automatic test_backpressure();
    set_arch(erwp_pkg::ARCH_ARM);
    send_idle_pct = 0;
    stall_pct = 0;
    tready_hold = 300;
    repeat (40) send_random();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_arm();
    test_directed_i386();
    test_random(400, erwp_pkg::ARCH_ARM, 0, 0);
    test_random(400, erwp_pkg::ARCH_I386, 57, 0);
    test_random(400, erwp_pkg::ARCH_ARM, 0, 57);
    test_random(400, erwp_pkg::ARCH_I386, 31, 31);
    test_backpressure();
    drain();
    if (bad_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/erwp_pkg.sv
rtl/erwp_front.sv
rtl/erwp_fifo.sv
rtl/erwp_back.sv
rtl/elf_reloc_word_patcher.sv
rtl/erwp_checker.sv
verif/testbench.sv
